@@ design/tun_pkg.sv @@
// shared widths and types for the triangle unit normal pipeline
package tun_pkg;

    localparam int COORD_W   = 24;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int HALF_W    = MAG_W / 2;
    localparam int SUM_W     = 2 * MAG_W;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int OUT_FRAC  = 30;
    localparam int QUOT_W    = OUT_FRAC + 1;
    localparam int OUT_W     = 32;
    localparam int NUM_PTS   = 9;

    typedef struct packed {
        logic                  degen;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } t_side;

    typedef struct packed {
        logic             degen;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_comp;

endpackage

@@ design/triangle_unit_normal.sv @@
// Unit face normal of a triangle: nine signed Q12.12 vertex coordinates in, the
// normalized cross product of both edges from the first vertex out as x, y and z
// components in signed Q2.30 plus a degenerate flag (zero-area triangle, normal zero).
// Fully pipelined: a new triangle can enter every cycle while the output side
// is not stalled. Each passes through the edges and cross product, the squared
// length, the bit-per-stage square root, the bit-per-stage dividers (one per
// component, in parallel) and 1 output stage. A stall on the output side
// freezes the whole pipeline; nothing is dropped.
module triangle_unit_normal (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [95:0]  m_axis_tdata,
    // degenerate
    output logic         m_axis_tuser
);

    logic                        w_en;
    logic                        w_cr_vld;
    tun_pkg::t_side              w_cr_side;
    logic                        w_sq_vld;
    tun_pkg::t_side              w_sq_side;
    logic [tun_pkg::SUM_W-1:0]   w_sq_sum;
    logic                        w_rt_vld;
    tun_pkg::t_side              w_rt_side;
    logic [tun_pkg::ROOT_W-1:0]  w_root;
    logic                        w_dv_vld [3];
    tun_pkg::t_comp              w_dv_comp [3];
    logic [tun_pkg::QUOT_W-1:0]  w_quot [3];
    logic [tun_pkg::OUT_W-1:0]   n_norm [3];

    logic                        r_out_vld;
    logic [tun_pkg::OUT_W-1:0]   r_norm [3];
    logic                        r_degen;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    tun_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_pts   (s_axis_tdata),
        .o_vld   (w_cr_vld),
        .o_side  (w_cr_side)
    );

    tun_nsq u_nsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_cr_vld),
        .i_side  (w_cr_side),
        .o_vld   (w_sq_vld),
        .o_side  (w_sq_side),
        .o_sum   (w_sq_sum)
    );

    tun_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_side  (w_sq_side),
        .i_sum   (w_sq_sum),
        .o_vld   (w_rt_vld),
        .o_side  (w_rt_side),
        .o_root  (w_root)
    );

    for (genvar k = 0; k < 3; k++) begin : g_div
        tun_pkg::t_comp w_comp;

        assign w_comp.degen = w_rt_side.degen;
        assign w_comp.neg   = w_rt_side.neg[k];
        assign w_comp.mag   = w_rt_side.mag[k];

        tun_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_rt_vld),
            .i_comp  (w_comp),
            .i_len   (w_root),
            .o_vld   (w_dv_vld[k]),
            .o_comp  (w_dv_comp[k]),
            .o_quot  (w_quot[k])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [tun_pkg::OUT_W-1:0] n_mag;
            n_mag = {{(tun_pkg::OUT_W-tun_pkg::QUOT_W){1'b0}}, w_quot[k]};
            if (w_quot[k] > (tun_pkg::QUOT_W'(1) << tun_pkg::OUT_FRAC)) begin
                n_mag = tun_pkg::OUT_W'(1) << tun_pkg::OUT_FRAC;
            end
            if (w_dv_comp[k].degen) begin
                n_norm[k] = '0;
            end else if (w_dv_comp[k].neg) begin
                n_norm[k] = -n_mag;
            end else begin
                n_norm[k] = n_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_norm[0] <= n_norm[0];
            r_norm[1] <= n_norm[1];
            r_norm[2] <= n_norm[2];
            r_degen   <= w_dv_comp[0].degen;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_norm[2], r_norm[1], r_norm[0]};
    assign m_axis_tuser  = r_degen;

    // degenerate beat carries a zero normal
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_degen) |-> (m_axis_tdata == '0))
        else $error("degenerate beat with nonzero normal");

    // a real triangle never yields an all-zero normal
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_degen) |-> (m_axis_tdata != '0))
        else $error("zero normal on non-degenerate beat");

    // x component stays within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (($signed(r_norm[0]) <= $signed(32'h4000_0000))
                    && ($signed(r_norm[0]) >= $signed(32'hC000_0000))))
        else $error("normal x out of range");

endmodule

@@ design/tun_cross.sv @@
// edge vectors, cross product and component magnitudes
module tun_cross (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [tun_pkg::NUM_PTS-1:0][tun_pkg::COORD_W-1:0] i_pts,
    output logic                                  o_vld,
    output tun_pkg::t_side                        o_side
);

    logic [3:0] r_vld;
    logic signed [tun_pkg::EDGE_W-1:0]  r_a [3];
    logic signed [tun_pkg::EDGE_W-1:0]  r_b [3];
    logic signed [tun_pkg::PROD_W-1:0]  r_p [6];
    logic signed [tun_pkg::CROSS_W-1:0] r_c [3];
    tun_pkg::t_side r_side;
    logic signed [tun_pkg::CROSS_W-1:0] w_neg_c [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_neg_c[k] = -r_c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= $signed({i_pts[3+k][tun_pkg::COORD_W-1], i_pts[3+k]})
                        - $signed({i_pts[k][tun_pkg::COORD_W-1], i_pts[k]});
                r_b[k] <= $signed({i_pts[6+k][tun_pkg::COORD_W-1], i_pts[6+k]})
                        - $signed({i_pts[k][tun_pkg::COORD_W-1], i_pts[k]});
            end
            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_b[1] * r_a[2];
            r_p[2] <= r_b[0] * r_a[2];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_b[0] * r_a[1];
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= $signed({r_p[2*k][tun_pkg::PROD_W-1], r_p[2*k]})
                        - $signed({r_p[2*k+1][tun_pkg::PROD_W-1], r_p[2*k+1]});
            end
            for (int k = 0; k < 3; k++) begin
                r_side.neg[k] <= r_c[k][tun_pkg::CROSS_W-1];
                r_side.mag[k] <= r_c[k][tun_pkg::CROSS_W-1]
                               ? w_neg_c[k][tun_pkg::MAG_W-1:0]
                               : r_c[k][tun_pkg::MAG_W-1:0];
            end
            r_side.degen <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        end
    end

    assign o_vld  = r_vld[3];
    assign o_side = r_side;

endmodule

@@ design/tun_nsq.sv @@
// squared length of the cross product from split partial products
module tun_nsq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  tun_pkg::t_side              i_side,
    output logic                        o_vld,
    output tun_pkg::t_side              o_side,
    output logic [tun_pkg::SUM_W-1:0]   o_sum
);

    logic [2:0] r_vld;
    tun_pkg::t_side r_side [3];
    logic [2*tun_pkg::HALF_W-1:0] r_hh [3];
    logic [2*tun_pkg::HALF_W-1:0] r_hl [3];
    logic [2*tun_pkg::HALF_W-1:0] r_ll [3];
    logic [tun_pkg::SUM_W-1:0]    r_sq [3];
    logic [tun_pkg::SUM_W-1:0]    r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= i_side.mag[k][tun_pkg::MAG_W-1:tun_pkg::HALF_W]
                         * i_side.mag[k][tun_pkg::MAG_W-1:tun_pkg::HALF_W];
                r_hl[k] <= i_side.mag[k][tun_pkg::MAG_W-1:tun_pkg::HALF_W]
                         * i_side.mag[k][tun_pkg::HALF_W-1:0];
                r_ll[k] <= i_side.mag[k][tun_pkg::HALF_W-1:0]
                         * i_side.mag[k][tun_pkg::HALF_W-1:0];
                r_sq[k] <= ({r_hh[k], {(2*tun_pkg::HALF_W){1'b0}}})
                         + ({{(tun_pkg::SUM_W-2*tun_pkg::HALF_W-tun_pkg::HALF_W-1){1'b0}},
                             r_hl[k], {(tun_pkg::HALF_W+1){1'b0}}})
                         + ({{(tun_pkg::SUM_W-2*tun_pkg::HALF_W){1'b0}}, r_ll[k]});
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_vld  = r_vld[2];
    assign o_side = r_side[2];
    assign o_sum  = r_sum;

endmodule

@@ design/tun_sqrt.sv @@
// floor square root, one root bit per pipeline stage
module tun_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  tun_pkg::t_side               i_side,
    input  logic [tun_pkg::SUM_W-1:0]    i_sum,
    output logic                         o_vld,
    output tun_pkg::t_side               o_side,
    output logic [tun_pkg::ROOT_W-1:0]   o_root
);

    localparam int N = tun_pkg::ROOT_W;

    logic                         w_vld  [N+1];
    tun_pkg::t_side               w_side [N+1];
    logic [tun_pkg::SUM_W-1:0]    w_rad  [N+1];
    logic [tun_pkg::SREM_W-1:0]   w_rem  [N+1];
    logic [tun_pkg::ROOT_W-1:0]   w_root [N+1];

    assign w_vld[0]  = i_vld;
    assign w_side[0] = i_side;
    assign w_rad[0]  = i_sum;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic                         r_vld;
        tun_pkg::t_side               r_side;
        logic [tun_pkg::SUM_W-1:0]    r_rad;
        logic [tun_pkg::SREM_W-1:0]   r_rem;
        logic [tun_pkg::ROOT_W-1:0]   r_root;
        logic [tun_pkg::SREM_W+1:0]   n_cur;
        logic [tun_pkg::SREM_W+1:0]   n_trial;
        logic [tun_pkg::SREM_W+1:0]   n_diff;
        logic                         n_ge;

        always_comb begin
            n_cur   = {w_rem[g], w_rad[g][tun_pkg::SUM_W-1 -: 2]};
            n_trial = {2'b00, w_root[g], 2'b01};
            n_diff  = n_cur - n_trial;
            n_ge    = (n_cur >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[g];
                r_rad  <= {w_rad[g][tun_pkg::SUM_W-3:0], 2'b00};
                r_rem  <= n_ge ? n_diff[tun_pkg::SREM_W-1:0] : n_cur[tun_pkg::SREM_W-1:0];
                r_root <= {w_root[g][tun_pkg::ROOT_W-2:0], n_ge};
            end
        end

        assign w_vld[g+1]  = r_vld;
        assign w_side[g+1] = r_side;
        assign w_rad[g+1]  = r_rad;
        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
    end

    assign o_vld  = w_vld[N];
    assign o_side = w_side[N];
    assign o_root = w_root[N];

endmodule

@@ design/tun_div.sv @@
// restoring divider for one component, one quotient bit per stage
module tun_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  tun_pkg::t_comp               i_comp,
    input  logic [tun_pkg::ROOT_W-1:0]   i_len,
    output logic                         o_vld,
    output tun_pkg::t_comp               o_comp,
    output logic [tun_pkg::QUOT_W-1:0]   o_quot
);

    localparam int N = tun_pkg::QUOT_W;

    logic                         w_vld  [N+1];
    tun_pkg::t_comp               w_comp [N+1];
    logic [tun_pkg::ROOT_W-1:0]   w_len  [N+1];
    logic [tun_pkg::ROOT_W-1:0]   w_rem  [N+1];
    logic [tun_pkg::QUOT_W-1:0]   w_quot [N+1];

    assign w_vld[0]  = i_vld;
    assign w_comp[0] = i_comp;
    assign w_len[0]  = i_len;
    assign w_rem[0]  = {1'b0, i_comp.mag[tun_pkg::MAG_W-1:1]};
    assign w_quot[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic                         r_vld;
        tun_pkg::t_comp               r_comp;
        logic [tun_pkg::ROOT_W-1:0]   r_len;
        logic [tun_pkg::ROOT_W-1:0]   r_rem;
        logic [tun_pkg::QUOT_W-1:0]   r_quot;
        logic [tun_pkg::ROOT_W:0]     n_cur;
        logic [tun_pkg::ROOT_W:0]     n_diff;
        logic                         n_ge;

        always_comb begin
            n_cur  = {w_rem[g], (g == 0) ? w_comp[g].mag[0] : 1'b0};
            n_ge   = (n_cur >= {1'b0, w_len[g]});
            n_diff = n_cur - {1'b0, w_len[g]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_comp <= w_comp[g];
                r_len  <= w_len[g];
                r_rem  <= n_ge ? n_diff[tun_pkg::ROOT_W-1:0] : n_cur[tun_pkg::ROOT_W-1:0];
                r_quot <= {w_quot[g][tun_pkg::QUOT_W-2:0], n_ge};
            end
        end

        assign w_vld[g+1]  = r_vld;
        assign w_comp[g+1] = r_comp;
        assign w_len[g+1]  = r_len;
        assign w_rem[g+1]  = r_rem;
        assign w_quot[g+1] = r_quot;
    end

    assign o_vld  = w_vld[N];
    assign o_comp = w_comp[N];
    assign o_quot = w_quot[N];

endmodule

@@ test/tun_checker.sv @@
// checker for the triangle unit normal: predicts each normal and compares output beats
module tun_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [215:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [95:0]  i_out_data,
    input  logic         i_out_degen,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        degen;
        logic [31:0] nz;
        logic [31:0] ny;
        logic [31:0] nx;
    } t_normal;

    t_normal normal_q[$];

    function automatic logic [139:0] int_root(logic [139:0] s);
        logic [139:0] r;
        logic [139:0] t;
        r = '0;
        for (int b = 69; b >= 0; b--) begin
            t = r | (140'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] unit_comp(logic signed [71:0] c, logic [139:0] len);
        logic [139:0] mag;
        logic [139:0] q;
        mag = c < 0 ? -c : c;
        q = (mag << tun_pkg::OUT_FRAC) / len;
        if (q > (140'd1 << tun_pkg::OUT_FRAC)) q = 140'd1 << tun_pkg::OUT_FRAC;
        return c < 0 ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_normal face_normal(logic [215:0] d);
        logic signed [71:0] p [9];
        logic signed [71:0] a [3];
        logic signed [71:0] b [3];
        logic signed [71:0] c [3];
        logic [139:0] s;
        logic [139:0] len;
        t_normal r;
        for (int k = 0; k < 9; k++) p[k] = $signed(d[k*24 +: 24]);
        for (int k = 0; k < 3; k++) begin
            a[k] = p[3+k] - p[k];
            b[k] = p[6+k] - p[k];
        end
        c[0] = a[1] * b[2] - b[1] * a[2];
        c[1] = b[0] * a[2] - a[0] * b[2];
        c[2] = a[0] * b[1] - b[0] * a[1];
        s = '0;
        for (int k = 0; k < 3; k++) s += 140'(c[k]) * 140'(c[k]);
        r = '0;
        if (s == 0) begin
            r.degen = 1'b1;
        end else begin
            len = int_root(s);
            r.nx = unit_comp(c[0], len);
            r.ny = unit_comp(c[1], len);
            r.nz = unit_comp(c[2], len);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_normal want;
        t_normal got;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                normal_q.insert(normal_q.size(), face_normal(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = {i_out_degen, i_out_data};
                if (normal_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected output beat %h", got);
                end else begin
                    want = normal_q.pop_front();
                    if (want != got) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: want x %h y %h z %h d %b, got x %h y %h z %h d %b",
                                     want.nx, want.ny, want.nz, want.degen,
                                     got.nx, got.ny, got.nz, got.degen);
                    end
                end
            end
            o_pending <= normal_q.size();
        end
    end
endmodule

@@ test/tb_triangle_unit_normal.sv @@
// testbench top for the triangle unit normal: stimulus, flow control and verdict
module tb_triangle_unit_normal;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RAND = 900;
    localparam int WATCHDOG = 5000;
    localparam int DRAIN = 200;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [215:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [95:0]  m_data;
    logic         m_user;
    int           errors;
    int           pending;
    int           idle_cycles = 0;
    bit           tail = 1'b0;
    bit           hold = 1'b0;

    always #5 i_clk = ~i_clk;

    triangle_unit_normal i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .m_axis_tuser(m_user)
    );

    tun_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_out_degen(m_user), .o_errors(errors), .o_pending(pending)
    );

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 16)) - 24'd8;
            3: return 24'($urandom_range(0, 8192)) - 24'd4096;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [215:0] rand_triangle();
        logic [215:0] d;
        for (int k = 0; k < 9; k++) d[k*24 +: 24] = rand_coord();
        case ($urandom_range(0, 9))
            0: d[215:72] = {d[71:0], d[71:0]};
            1: d[143:72] = d[71:0];
            2: for (int k = 0; k < 3; k++)
                   d[(6+k)*24 +: 24] = 24'(2 * d[(3+k)*24 +: 24] - d[k*24 +: 24]);
            default: ;
        endcase
        return d;
    endfunction

    task automatic send(logic [215:0] d);
        int gap;
        if (!tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && !((s_valid && s_ready) || (m_valid && m_ready))
            && (pending > 0 || s_valid))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_triangle_unit_normal: done, errors");
            $finish;
        end
    end

    initial begin
        int n;
        @(posedge i_clk);
        while (1) begin
            if (hold || (!tail && $urandom_range(0, 3) == 0)) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 10);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 20);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin
        logic [215:0] d;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send('0);
        send({9{24'h7FFFFF}});
        send({9{24'h800000}});
        send({24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
              24'h800000, 24'h800000, 24'h800000});
        send({24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF,
              24'h800000, 24'h800000, 24'h800000});
        send({24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        send({24'd0, 24'd4096, 24'd0, 24'd0, 24'd0, 24'd4096, 24'd0, 24'd0, 24'd0});
        send({24'd0, 24'd0, 24'hFFF000, 24'd0, 24'hFFF000, 24'd0, 24'd0, 24'd0, 24'd0});
        send({24'd3, 24'd2, 24'd1, 24'd3, 24'd2, 24'd1, 24'd7, 24'd5, 24'd9});
        send({24'd6, 24'd4, 24'd2, 24'd3, 24'd2, 24'd1, 24'd0, 24'd0, 24'd0});
        send({24'd1, 24'd1, 24'd1, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0});
        send({24'd5, 24'd7, 24'd1, 24'd2, 24'd3, 24'hFFFFFF, 24'd1, 24'd9, 24'd4});
        hold <= 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold <= 1'b0;
            end
            for (int i = 0; i < 150; i++) send(rand_triangle());
        join
        for (int i = 0; i < N_RAND - 150; i++) begin
            if (i == N_RAND - 300) tail = 1'b1;
            send(rand_triangle());
        end
        s_valid <= 1'b0;
        while (pending > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_triangle_unit_normal: done, clean");
        else
            $display("tb_triangle_unit_normal: done, errors");
        $finish;
    end
endmodule
